// ----- rtl/bgp_pkg.sv -----
// Package of shared payload types and constants for the bilinear gradient pixel block.
`timescale 1ns / 1ps
package bgp_pkg;

   // Width of the colour channels and the number of channels per pixel.
   localparam int ChanWidth = 8;
   localparam int NumChan   = 3;

   // Register map, word index into the configuration space.
   localparam logic [2:0] RegWidth       = 3'd0;
   localparam logic [2:0] RegHeight      = 3'd1;
   localparam logic [2:0] RegTopLeft     = 3'd2;
   localparam logic [2:0] RegTopRight    = 3'd3;
   localparam logic [2:0] RegBottomLeft  = 3'd4;
   localparam logic [2:0] RegBottomRight = 3'd5;

   // Reset values of the image size registers.
   localparam logic [12:0] WidthReset  = 13'd640;
   localparam logic [12:0] HeightReset = 13'd480;

   // Largest channel value.
   localparam logic [7:0] ChanMax = 8'd255;

   // Input item: one pixel coordinate.
   typedef struct packed {
      logic [11:0] column;
      logic [11:0] row;
   } req_payload_type;

   // Result item: one pixel colour.
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rsp_payload_type;

endpackage

// ----- rtl/bilinear_gradient_pixel.sv -----
// Top level of the four-corner bilinear gradient pixel generator.
// Usage:
// The req channel takes one pixel coordinate (column, row) per transfer and
// the rsp channel returns its blue, green and red values, one result per
// request, in order. Coordinates past the image saturate to the last column
// or row. The csr port is an APB-style register file holding the image size
// and the four corner colours; write it only while no pixel is in flight.
// A req transfer reaches a valid rsp result through four front-end
// stages (saturation, weight products, colour products, numerator sum),
// a chain of eight divider cells, one quotient bit each, and the
// rounding output register. Throughput is one pixel per clock while the
// receiver does not stall, set by the fully pipelined cell chain.
// When the receiver stalls, the whole pipeline holds and req_ready falls
// while the output register is full and rsp_ready is low.
// A synchronous reset empties the pipeline and loads the default size of
// 640 by 480 with all corners black.
`timescale 1ns / 1ps
module bilinear_gradient_pixel #(
   parameter int MAX_SIDE = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bgp_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bgp_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [4:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   localparam int SW     = ($clog2(MAX_SIDE) > 13) ? 13 : $clog2(MAX_SIDE);
   localparam int NW     = 2 * SW + 8;
   localparam int NCELLS = 8;

   // Configuration registers.
   logic [12:0] width_ff, height_ff;
   logic [23:0] tl_ff, tr_ff, bl_ff, br_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bgp_pkg::WidthReset;
         height_ff <= bgp_pkg::HeightReset;
         tl_ff     <= 24'd0;
         tr_ff     <= 24'd0;
         bl_ff     <= 24'd0;
         br_ff     <= 24'd0;
      end else if (csr_wr) begin
         case (csr_idx)
            bgp_pkg::RegWidth:       width_ff  <= csr_pwdata[12:0];
            bgp_pkg::RegHeight:      height_ff <= csr_pwdata[12:0];
            bgp_pkg::RegTopLeft:     tl_ff     <= csr_pwdata[23:0];
            bgp_pkg::RegTopRight:    tr_ff     <= csr_pwdata[23:0];
            bgp_pkg::RegBottomLeft:  bl_ff     <= csr_pwdata[23:0];
            bgp_pkg::RegBottomRight: br_ff     <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_idx)
         bgp_pkg::RegWidth:       csr_prdata = {19'd0, width_ff};
         bgp_pkg::RegHeight:      csr_prdata = {19'd0, height_ff};
         bgp_pkg::RegTopLeft:     csr_prdata = {8'd0, tl_ff};
         bgp_pkg::RegTopRight:    csr_prdata = {8'd0, tr_ff};
         bgp_pkg::RegBottomLeft:  csr_prdata = {8'd0, bl_ff};
         bgp_pkg::RegBottomRight: csr_prdata = {8'd0, br_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   // The pipeline moves whenever the output register can take a result.
   logic rsp_valid_ff;
   logic en;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Front end and the divider cell chain.
   logic [NCELLS:0]                                   c_valid;
   logic [NCELLS:0][2*SW-1:0]                         c_den;
   logic [NCELLS:0][bgp_pkg::NumChan-1:0][NW-1:0]     c_rem;
   logic [NCELLS:0][bgp_pkg::NumChan-1:0][7:0]        c_quo;

   bgp_prep #(.MAX_SIDE(MAX_SIDE), .SW(SW)) u_prep (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .in_data      (req_data),
      .image_width  (width_ff),
      .image_height (height_ff),
      .corner_tl    (tl_ff),
      .corner_tr    (tr_ff),
      .corner_bl    (bl_ff),
      .corner_br    (br_ff),
      .out_valid    (c_valid[0]),
      .out_den      (c_den[0]),
      .out_num      (c_rem[0])
   );

   assign c_quo[0] = '0;

   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      bgp_div_cell #(.SW(SW), .SHIFT(NCELLS - 1 - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (c_valid[i]),
         .in_den    (c_den[i]),
         .in_rem    (c_rem[i]),
         .in_quo    (c_quo[i]),
         .out_valid (c_valid[i+1]),
         .out_den   (c_den[i+1]),
         .out_rem   (c_rem[i+1]),
         .out_quo   (c_quo[i+1])
      );
   end

   // Round to nearest with ties to even, then clamp.
   logic [bgp_pkg::NumChan-1:0][7:0] chan_in;
   logic [2*SW:0]                    twice_r, den_x;
   logic [8:0]                       rounded;
   logic                             up;

   always_comb begin
      den_x = {1'b0, c_den[NCELLS]};
      for (int c = 0; c < bgp_pkg::NumChan; c++) begin
         twice_r = {c_rem[NCELLS][c][2*SW-1:0], 1'b0};
         up = (twice_r > den_x) || ((twice_r == den_x) && c_quo[NCELLS][c][0]);
         rounded = {1'b0, c_quo[NCELLS][c]} + {8'd0, up};
         chan_in[c] = (rounded > {1'b0, bgp_pkg::ChanMax}) ? bgp_pkg::ChanMax
                                                           : rounded[7:0];
      end
   end

   // Output register.
   bgp_pkg::rsp_payload_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= c_valid[NCELLS];
      end
      if (en) begin
         rsp_data_ff.blue  <= chan_in[0];
         rsp_data_ff.green <= chan_in[1];
         rsp_data_ff.red   <= chan_in[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/bgp_prep.sv -----
// Front end: coordinate saturation, corner weights, denominator and channel numerators.
`timescale 1ns / 1ps
module bgp_prep #(
   parameter int MAX_SIDE = 4096,
   parameter int SW       = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  bgp_pkg::req_payload_type              in_data,
   input  logic [12:0]                           image_width,
   input  logic [12:0]                           image_height,
   input  logic [23:0]                           corner_tl,
   input  logic [23:0]                           corner_tr,
   input  logic [23:0]                           corner_bl,
   input  logic [23:0]                           corner_br,
   output logic                                  out_valid,
   output logic [2*SW-1:0]                       out_den,
   output logic [bgp_pkg::NumChan-1:0][2*SW+7:0] out_num
);
   localparam int NW = 2 * SW + 8;

   // Stage one: clamp the sizes, saturate the coordinate and form the spans.
   logic [31:0]   w_sz, h_sz, wm1, hm1;
   logic [SW-1:0] spanx_in, spany_in, xs_in, ys_in;
   logic [SW-1:0] spanx_ff, spany_ff, xs_ff, ys_ff;
   logic          v1_ff;

   always_comb begin
      w_sz = {19'd0, image_width};
      h_sz = {19'd0, image_height};
      if (w_sz == 32'd0) begin
         w_sz = 32'd1;
      end else if (w_sz > 32'(MAX_SIDE)) begin
         w_sz = 32'(MAX_SIDE);
      end
      if (h_sz == 32'd0) begin
         h_sz = 32'd1;
      end else if (h_sz > 32'(MAX_SIDE)) begin
         h_sz = 32'(MAX_SIDE);
      end
      wm1 = w_sz - 32'd1;
      hm1 = h_sz - 32'd1;
      // A size of one still spans one step, with all weight on the first corner.
      spanx_in = (w_sz > 32'd1) ? wm1[SW-1:0] : SW'(1);
      spany_in = (h_sz > 32'd1) ? hm1[SW-1:0] : SW'(1);
      xs_in = ({20'd0, in_data.column} > wm1) ? wm1[SW-1:0] : SW'(in_data.column);
      ys_in = ({20'd0, in_data.row} > hm1) ? hm1[SW-1:0] : SW'(in_data.row);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         spanx_ff <= spanx_in;
         spany_ff <= spany_in;
         xs_ff    <= xs_in;
         ys_ff    <= ys_in;
      end
   end

   // Stage two: pairwise weight products and the denominator.
   logic [SW-1:0]   wl, wt;
   logic [2*SW-1:0] ptl_ff, ptr_ff, pbl_ff, pbr_ff, den2_ff;
   logic            v2_ff;

   assign wl = spanx_ff - xs_ff;
   assign wt = spany_ff - ys_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         ptl_ff  <= wl * wt;
         ptr_ff  <= xs_ff * wt;
         pbl_ff  <= wl * ys_ff;
         pbr_ff  <= xs_ff * ys_ff;
         den2_ff <= spanx_ff * spany_ff;
      end
   end

   // Stage three: weight times corner colour, per channel and corner.
   logic [bgp_pkg::NumChan-1:0][3:0][NW-1:0] term_ff;
   logic [2*SW-1:0]                          den3_ff;
   logic                                     v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         den3_ff <= den2_ff;
         for (int c = 0; c < bgp_pkg::NumChan; c++) begin
            term_ff[c][0] <= NW'(ptl_ff) * NW'(corner_tl[8*c +: 8]);
            term_ff[c][1] <= NW'(ptr_ff) * NW'(corner_tr[8*c +: 8]);
            term_ff[c][2] <= NW'(pbl_ff) * NW'(corner_bl[8*c +: 8]);
            term_ff[c][3] <= NW'(pbr_ff) * NW'(corner_br[8*c +: 8]);
         end
      end
   end

   // Stage four: sum the four terms into the exact numerator.
   logic [bgp_pkg::NumChan-1:0][NW-1:0] num_ff;
   logic [2*SW-1:0]                     den4_ff;
   logic                                v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         den4_ff <= den3_ff;
         for (int c = 0; c < bgp_pkg::NumChan; c++) begin
            num_ff[c] <= term_ff[c][0] + term_ff[c][1] + term_ff[c][2] + term_ff[c][3];
         end
      end
   end

   assign out_valid = v4_ff;
   assign out_den   = den4_ff;
   assign out_num   = num_ff;

endmodule

// ----- rtl/bgp_div_cell.sv -----
// One cell of the restoring divider: settles one quotient bit for all three channels.
`timescale 1ns / 1ps
module bgp_div_cell #(
   parameter int SW    = 12,
   parameter int SHIFT = 7
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [2*SW-1:0]                       in_den,
   input  logic [bgp_pkg::NumChan-1:0][2*SW+7:0] in_rem,
   input  logic [bgp_pkg::NumChan-1:0][7:0]      in_quo,
   output logic                                  out_valid,
   output logic [2*SW-1:0]                       out_den,
   output logic [bgp_pkg::NumChan-1:0][2*SW+7:0] out_rem,
   output logic [bgp_pkg::NumChan-1:0][7:0]      out_quo
);
   localparam int NW = 2 * SW + 8;

   // Trial subtraction of the shifted divisor from each partial remainder.
   logic [NW-1:0]                       dsh;
   logic [bgp_pkg::NumChan-1:0][NW-1:0] rem_in;
   logic [bgp_pkg::NumChan-1:0][7:0]    quo_in;

   always_comb begin
      dsh = NW'(in_den) << SHIFT;
      for (int c = 0; c < bgp_pkg::NumChan; c++) begin
         if (in_rem[c] >= dsh) begin
            rem_in[c] = in_rem[c] - dsh;
            quo_in[c] = in_quo[c] | (8'd1 << SHIFT);
         end else begin
            rem_in[c] = in_rem[c];
            quo_in[c] = in_quo[c];
         end
      end
   end

   logic                                valid_ff;
   logic [2*SW-1:0]                     den_ff;
   logic [bgp_pkg::NumChan-1:0][NW-1:0] rem_ff;
   logic [bgp_pkg::NumChan-1:0][7:0]    quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         den_ff <= in_den;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_den   = den_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;

endmodule
